/* rtl/core/hash_table_probe_chain_core_assert.svh */
// assertion macros for the hash table probe and chain core
`ifndef HASH_TABLE_PROBE_CHAIN_CORE_ASSERT_SVH
`define HASH_TABLE_PROBE_CHAIN_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define HTPC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HTPC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define HTPC_CHECK(lbl, prop, msg)

`define HTPC_CHECK_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/htpc_pkg.sv */
// shared widths, request kinds and status codes of the hash table core
`timescale 1ns / 1ps

package htpc_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CNT_W    = $clog2(KEY_W);

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 7'd64;

  localparam logic [KIND_W-1:0] KIND_LINEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAIN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

/* rtl/core/htpc_if.sv */
// request, response and configuration channel interfaces
`timescale 1ns / 1ps

interface htpc_req_if import htpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface htpc_rsp_if import htpc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

interface htpc_cfg_if import htpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink   (input valid, input table_size, output ready);
endinterface

/* rtl/core/hash_table_probe_chain_core.sv */
// Steps: accept the request, reduce the key modulo the table size bit-serially,
// read the home slot, then read the probed or walked slots in turn (a chained
// insert walks the chain, then probes), link and write a chained insert, respond.
// One request at a time; the request rate is set by the bit-serial modulo unit
// and the single read port of the slot ram.
// Reset: a clearing pass over all TABLE_DEPTH slots, no requests taken meanwhile.
`timescale 1ns / 1ps
`include "hash_table_probe_chain_core_assert.svh"

module hash_table_probe_chain_core import htpc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  htpc_req_if.sink    in_if,
  htpc_rsp_if.source  out_if,
  htpc_cfg_if.sink    cfg_if
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (SW > CFG_W) ? SW : CFG_W;

  localparam int unsigned VAL_LSB  = 0;
  localparam int unsigned KEY_LSB  = VAL_W;
  localparam int unsigned TGT_LSB  = VAL_W + KEY_W;
  localparam int unsigned LV_BIT   = TGT_LSB + AW;
  localparam int unsigned USED_BIT = LV_BIT + 1;
  localparam int unsigned MW       = USED_BIT + 1;

  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_MOD    = 11'b00000000100,
    S_HOME   = 11'b00000001000,
    S_LPROBE = 11'b00000010000,
    S_CHOME  = 11'b00000100000,
    S_CWALK  = 11'b00001000000,
    S_CPROBE = 11'b00010000000,
    S_CREC   = 11'b00100000000,
    S_DEL    = 11'b01000000000,
    S_RESP   = 11'b10000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    tsz_r, tsz_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [SW-1:0]       n_r, n_nxt;
  logic [KEY_W-1:0]    div_r, div_nxt;
  logic [SW-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]       home_r, home_nxt;
  logic [AW-1:0]       cur_r, cur_nxt;
  logic [SW-1:0]       steps_r, steps_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [MW-1:0]       tent_r, tent_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [AW:0]         ilink_r, ilink_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [AW-1:0]       where_r, where_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [MW-1:0]       rd_word;

  logic                rd_used;
  logic                rd_lv;
  logic [AW-1:0]       rd_tgt;
  logic [KEY_W-1:0]    rd_key;
  logic [VAL_W-1:0]    rd_val;

  logic [CW-1:0]       tsz_ext;
  logic [SW-1:0]       n_eff;
  logic [SW:0]         rem_shift;
  logic [SW-1:0]       rem_step;
  logic [SW-1:0]       cur_p1;
  logic [AW-1:0]       cur_inc;
  logic                inc_home;
  logic                follow;
  logic [AW:0]         rec_link;

  htpc_ram #(
    .WIDTH (MW),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_word)
  );

  assign rd_used = rd_word[USED_BIT];
  assign rd_lv   = rd_word[LV_BIT];
  assign rd_tgt  = rd_word[TGT_LSB +: AW];
  assign rd_key  = rd_word[KEY_LSB +: KEY_W];
  assign rd_val  = rd_word[VAL_LSB +: VAL_W];

  // effective table size
  always_comb begin
    tsz_ext = CW'(tsz_r);
    if (tsz_ext == '0) begin
      n_eff = SW'(1);
    end else if (tsz_ext > CW'(TABLE_DEPTH)) begin
      n_eff = SW'(TABLE_DEPTH);
    end else begin
      n_eff = SW'(tsz_ext);
    end
  end

  // one remainder bit per cycle
  assign rem_shift = {rem_r, div_r[KEY_W-1]};
  assign rem_step  = (rem_shift >= {1'b0, n_r}) ? SW'(rem_shift - {1'b0, n_r})
                                                : SW'(rem_shift);

  // wrapping slot increment
  assign cur_p1   = SW'(cur_r) + SW'(1);
  assign cur_inc  = (cur_p1 == n_r) ? '0 : AW'(cur_p1);
  assign inc_home = (cur_inc == home_r);
  assign follow   = rd_lv && (SW'(rd_tgt) < n_r) && (steps_r < n_r);
  assign rec_link = (idx_r == tail_r) ? {1'b1, idx_r} : ilink_r;

  assign in_if.ready       = (state_r == S_IDLE);
  assign cfg_if.ready      = 1'b1;
  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.slot_index = out_slot_r;

  always_comb begin
    state_nxt      = state_r;
    tsz_nxt        = tsz_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r & ~out_if.ready;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    n_nxt          = n_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    home_nxt       = home_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    tail_nxt       = tail_r;
    tent_nxt       = tent_r;
    idx_nxt        = idx_r;
    ilink_nxt      = ilink_r;
    st_nxt         = st_r;
    where_nxt      = where_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = {1'b1, rd_lv, rd_tgt, key_r, val_r};
    ram_raddr      = cur_r;

    if (cfg_if.valid) begin
      tsz_nxt = cfg_if.table_size;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_if.valid) begin
          kind_nxt  = in_if.kind;
          key_nxt   = in_if.key;
          val_nxt   = in_if.value;
          div_nxt   = in_if.key;
          n_nxt     = n_eff;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(KEY_W - 1);
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        rem_nxt = rem_step;
        div_nxt = div_r << 1;
        if (cnt_r == '0) begin
          home_nxt  = AW'(rem_step);
          state_nxt = S_HOME;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_HOME: begin
        ram_raddr = home_r;
        cur_nxt   = home_r;
        steps_nxt = '0;
        unique case (kind_r)
          KIND_LINEAR: state_nxt = S_LPROBE;
          KIND_CHAIN:  state_nxt = S_CHOME;
          KIND_DELETE: state_nxt = S_DEL;
          default: begin
            st_nxt    = ST_NOT_FOUND;
            where_nxt = '0;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_LPROBE: begin
        if (!rd_used) begin
          ram_we    = 1'b1;
          st_nxt    = ST_INSERTED;
          where_nxt = cur_r;
          state_nxt = S_RESP;
        end else if (inc_home) begin
          st_nxt    = ST_FULL;
          where_nxt = '0;
          state_nxt = S_RESP;
        end else begin
          ram_raddr = cur_inc;
          cur_nxt   = cur_inc;
        end
      end
      S_CHOME, S_CWALK: begin
        if ((state_r == S_CHOME) && !rd_used) begin
          ram_we    = 1'b1;
          st_nxt    = ST_INSERTED;
          where_nxt = cur_r;
          state_nxt = S_RESP;
        end else if (follow) begin
          ram_raddr = rd_tgt;
          cur_nxt   = rd_tgt;
          steps_nxt = steps_r + SW'(1);
          state_nxt = S_CWALK;
        end else begin
          tail_nxt  = cur_r;
          tent_nxt  = rd_word;
          ram_raddr = cur_inc;
          cur_nxt   = cur_inc;
          state_nxt = S_CPROBE;
        end
      end
      S_CPROBE: begin
        if (!rd_used) begin
          // link the chain end first, record goes in next cycle
          ram_we    = 1'b1;
          ram_waddr = tail_r;
          ram_wdata = {tent_r[USED_BIT], 1'b1, cur_r, tent_r[KEY_LSB +: KEY_W],
                       tent_r[VAL_LSB +: VAL_W]};
          idx_nxt   = cur_r;
          ilink_nxt = {rd_lv, rd_tgt};
          state_nxt = S_CREC;
        end else if (inc_home) begin
          st_nxt    = ST_FULL;
          where_nxt = '0;
          state_nxt = S_RESP;
        end else begin
          ram_raddr = cur_inc;
          cur_nxt   = cur_inc;
        end
      end
      S_CREC: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = {1'b1, rec_link, key_r, val_r};
        st_nxt    = ST_INSERTED;
        where_nxt = idx_r;
        state_nxt = S_RESP;
      end
      S_DEL: begin
        if (!rd_used) begin
          st_nxt    = ST_NOT_FOUND;
          where_nxt = '0;
          state_nxt = S_RESP;
        end else if (rd_key == key_r) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, 1'b0, rd_tgt, rd_key, rd_val};
          st_nxt    = ST_DELETED;
          where_nxt = cur_r;
          state_nxt = S_RESP;
        end else if (inc_home) begin
          st_nxt    = ST_NOT_FOUND;
          where_nxt = '0;
          state_nxt = S_RESP;
        end else begin
          ram_raddr = cur_inc;
          cur_nxt   = cur_inc;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_slot_nxt   = SLOT_W'(where_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      tsz_r       <= TABLE_SIZE_RST;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tsz_r       <= tsz_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    n_r          <= n_nxt;
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    home_r       <= home_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    tail_r       <= tail_nxt;
    tent_r       <= tent_nxt;
    idx_r        <= idx_nxt;
    ilink_r      <= ilink_nxt;
    st_r         <= st_nxt;
    where_r      <= where_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  `HTPC_CHECK(a_home_in_range, (state_r == S_HOME) |-> (SW'(home_r) < n_r), "home slot out of range")
  `HTPC_CHECK(a_probe_in_range, (state_r == S_LPROBE || state_r == S_CPROBE || state_r == S_DEL || state_r == S_CWALK) |-> (SW'(cur_r) < n_r), "probe slot out of range")
  `HTPC_CHECK(a_walk_bound, (state_r == S_CWALK) |-> (steps_r <= n_r), "chain walk exceeded table size")
  `HTPC_CHECK(a_no_write_idle, (state_r == S_IDLE || state_r == S_MOD || state_r == S_RESP) |-> !ram_we, "slot ram written outside a request")
  `HTPC_CHECK_NEXT(a_resp_load, (state_r == S_RESP) && (!out_valid_r || out_if.ready), out_valid_r && (state_r == S_IDLE), "response word not loaded")

endmodule

/* rtl/core/htpc_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module htpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* test/tb_hash_table_probe_chain_core.sv */
// testbench for the hash table core: directed and random requests against a table predictor
`timescale 1ns / 1ps

module tb_hash_table_probe_chain_core import htpc_pkg::*; ();

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 260;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } answer_t;

  class htpc_scoreboard;
    bit              slot_full [DEPTH];
    bit [KEY_W-1:0]  slot_key [DEPTH];
    bit              has_link [DEPTH];
    bit [SLOT_W-1:0] link_to [DEPTH];
    bit [CFG_W-1:0]  size_reg = TABLE_SIZE_RST;
    answer_t         answers_q[$];
    int              errors = 0;

    function int unsigned live_size();
      if (size_reg == 0) return 1;
      if (size_reg > DEPTH) return DEPTH;
      return 32'(size_reg);
    endfunction

    function int free_from(int unsigned start, int unsigned home, int unsigned n);
      int unsigned idx;
      idx = start;
      for (int unsigned steps = 0; steps <= n; steps++) begin
        if (!slot_full[idx]) return idx;
        idx = (idx + 1) % n;
        if (idx == home) return -1;
      end
      return -1;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
      int unsigned n;
      int unsigned home;
      int unsigned tail;
      int unsigned idx;
      int          hit;
      answer_t     a;
      n = live_size();
      home = key % n;
      a.status = ST_NOT_FOUND;
      a.slot = '0;
      case (kind)
        KIND_LINEAR: begin
          hit = free_from(home, home, n);
          if (hit >= 0) begin
            slot_full[hit] = 1'b1;
            slot_key[hit] = key;
            a.status = ST_INSERTED;
            a.slot = hit[SLOT_W-1:0];
          end else begin
            a.status = ST_FULL;
          end
        end
        KIND_CHAIN: begin
          if (!slot_full[home]) begin
            slot_full[home] = 1'b1;
            slot_key[home] = key;
            a.status = ST_INSERTED;
            a.slot = home[SLOT_W-1:0];
          end else begin
            tail = home;
            for (int unsigned steps = 0; steps < n; steps++) begin
              if (!has_link[tail] || link_to[tail] >= n) break;
              tail = 32'(link_to[tail]);
            end
            hit = free_from((tail + 1) % n, home, n);
            if (hit >= 0) begin
              has_link[tail] = 1'b1;
              link_to[tail] = hit[SLOT_W-1:0];
              slot_full[hit] = 1'b1;
              slot_key[hit] = key;
              a.status = ST_INSERTED;
              a.slot = hit[SLOT_W-1:0];
            end else begin
              a.status = ST_FULL;
            end
          end
        end
        KIND_DELETE: begin
          idx = home;
          for (int unsigned steps = 0; steps < n; steps++) begin
            if (!slot_full[idx]) break;
            if (slot_key[idx] == key) begin
              slot_full[idx] = 1'b0;
              has_link[idx] = 1'b0;
              a.status = ST_DELETED;
              a.slot = idx[SLOT_W-1:0];
              break;
            end
            idx = (idx + 1) % n;
            if (idx == home) break;
          end
        end
        default: ;
      endcase
      answers_q.push_back(a);
    endfunction

    function void check_answer(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot);
      answer_t a;
      if (answers_q.size() == 0) begin
        $error("response word with nothing outstanding: status %0d slot_index %0d",
               status, slot);
        errors++;
        return;
      end
      a = answers_q.pop_front();
      if (status !== a.status) begin
        $error("status: expected %0d, got %0d", a.status, status);
        errors++;
      end
      if (slot !== a.slot) begin
        $error("slot_index: expected %0d, got %0d", a.slot, slot);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  htpc_req_if in_if();
  htpc_rsp_if out_if();
  htpc_cfg_if cfg_if();

  hash_table_probe_chain_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  htpc_scoreboard sb = new();

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  logic [KEY_W-1:0] live_keys[$];
  logic [CFG_W-1:0] phase_size [PHASES] = '{7'd64, 7'd5, 7'd1, 7'd127, 7'd16, 7'd0, 7'd37};

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_answer(out_if.status, out_if.slot_index);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  task automatic send_req(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                          logic [VAL_W-1:0] value);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.key <= key;
    in_if.value <= value;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_request(kind, key);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.answers_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_W-1:0] size);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.table_size <= size;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    sb.size_reg = size;
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int unsigned n);
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = KEY_W'($urandom_range(0, 255));
      1: k = KEY_W'($urandom);
      2: k = KEY_W'({KEY_W{1'b1}} - $urandom_range(0, 255));
      default: k = KEY_W'($urandom_range(0, 15) * n + $urandom_range(0, 2));
    endcase
    return k;
  endfunction

  task automatic random_run(int count, int pause_at);
    int unsigned n;
    int r;
    int del_pct;
    int pick;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_drained();
      n = sb.live_size();
      r = $urandom_range(0, 99);
      del_pct = (live_keys.size() == 0) ? 0 : ((live_keys.size() > n) ? 55 : 25);
      if (r < 4) begin
        send_req(KIND_NONE, pick_key(n), VAL_W'($urandom_range(0, 65535)));
      end else if (r < 12) begin
        send_req(KIND_DELETE, pick_key(n), VAL_W'($urandom_range(0, 65535)));
      end else if (r < 12 + del_pct) begin
        pick = $urandom_range(0, live_keys.size() - 1);
        key = live_keys[pick];
        live_keys.delete(pick);
        send_req(KIND_DELETE, key, VAL_W'($urandom_range(0, 65535)));
      end else begin
        key = pick_key(n);
        live_keys.push_back(key);
        if (live_keys.size() > 200) void'(live_keys.pop_front());
        send_req($urandom_range(0, 1) ? KIND_CHAIN : KIND_LINEAR, key,
                 VAL_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.kind <= KIND_LINEAR;
    in_if.key <= '0;
    in_if.value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.table_size <= TABLE_SIZE_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 22;
    out_idle_pct = 56;

    // collisions, chain building and full table on a small table
    write_size(7'd4);
    send_req(KIND_LINEAR, 31'd0, 16'h0000);
    send_req(KIND_LINEAR, 31'd4, 16'hffff);
    send_req(KIND_CHAIN, 31'd8, 16'h1234);
    send_req(KIND_CHAIN, 31'd12, 16'habcd);
    send_req(KIND_LINEAR, 31'h7fffffff, 16'h5555);
    send_req(KIND_CHAIN, 31'd1, 16'haaaa);
    // links now point past the end of the table
    write_size(7'd2);
    send_req(KIND_CHAIN, 31'd10, 16'h0001);
    send_req(KIND_DELETE, 31'd0, 16'h0000);
    send_req(KIND_CHAIN, 31'd6, 16'h0002);
    write_size(7'd4);
    send_req(KIND_DELETE, 31'd8, 16'h0000);
    send_req(KIND_DELETE, 31'd99, 16'hffff);
    send_req(KIND_NONE, 31'd5, 16'hffff);
    send_req(KIND_CHAIN, 31'd16, 16'h0003);
    send_req(KIND_LINEAR, 31'd6, 16'h0004);
    // zero size acts as one slot
    write_size(7'd0);
    send_req(KIND_LINEAR, 31'h7fffffff, 16'hffff);
    send_req(KIND_DELETE, 31'd6, 16'h0000);
    send_req(KIND_CHAIN, 31'h7fffffff, 16'h0000);
    // oversize acts as full depth
    write_size(7'd65);
    send_req(KIND_LINEAR, 31'h7fffffff, 16'h0001);
    send_req(KIND_CHAIN, 31'd63, 16'h0002);
    send_req(KIND_CHAIN, 31'd127, 16'h0003);
    send_req(KIND_DELETE, 31'h7fffffff, 16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        in_idle_pct = 56;
        out_idle_pct = 22;
      end else if (p == 5) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      write_size(phase_size[p]);
      if (p == 1) hold_requests++;
      random_run(PHASE_ITEMS, (p == 4) ? PHASE_ITEMS / 2 : -1);
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.answers_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* hash_table_probe_chain_core.f */
+incdir+rtl/core
rtl/core/htpc_pkg.sv
rtl/core/htpc_if.sv
rtl/core/htpc_ram.sv
rtl/core/hash_table_probe_chain_core.sv
test/tb_hash_table_probe_chain_core.sv
